[hw/rtl/pmc_pkg.sv]
package pmc_pkg;

    // Operating modes, as reported on the result channel.
    typedef enum logic [2:0] {
        MODE_RUN   = 3'd0,
        MODE_CHG   = 3'd1,
        MODE_BWAIT = 3'd2,
        MODE_DEEP  = 3'd3,
        MODE_LIGHT = 3'd4
    } mode_t;

    // Transition codes.
    localparam logic [4:0] EV_NONE            = 5'd0;
    localparam logic [4:0] EV_BOOT_BWAIT      = 5'd1;
    localparam logic [4:0] EV_BOOT_DEEP       = 5'd2;
    localparam logic [4:0] EV_BOOT_CHG        = 5'd3;
    localparam logic [4:0] EV_BOOT_RUN        = 5'd4;
    localparam logic [4:0] EV_RUN_CUTOFF      = 5'd5;
    localparam logic [4:0] EV_RUN_SWITCH_OFF  = 5'd6;
    localparam logic [4:0] EV_RUN_USB         = 5'd7;
    localparam logic [4:0] EV_RUN_IDLE        = 5'd8;
    localparam logic [4:0] EV_CHG_USB_GONE    = 5'd9;
    localparam logic [4:0] EV_CHG_SWITCH_OFF  = 5'd10;
    localparam logic [4:0] EV_BWAIT_SWITCH_ON = 5'd11;
    localparam logic [4:0] EV_LIGHT_CUTOFF    = 5'd12;
    localparam logic [4:0] EV_LIGHT_SWITCH    = 5'd13;
    localparam logic [4:0] EV_LIGHT_LINK      = 5'd14;
    localparam logic [4:0] EV_LIGHT_MOTION    = 5'd15;
    localparam logic [4:0] EV_LIGHT_TIMEOUT   = 5'd16;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] CFG_IDLE_TMO    = 3'd1;
    localparam logic [2:0] CFG_GNSS_CUTOFF = 3'd2;
    localparam logic [2:0] CFG_SLEEP_TMO   = 3'd3;
    localparam logic [2:0] CFG_CHARGE_ONLY = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_W      = 11;
    // 2047 minutes in milliseconds fits in 27 bits.
    localparam int THR_W      = 27;
    localparam int MS_PER_MIN = 60000;

    localparam logic [15:0]      RST_DEBOUNCE_MS = 16'd500;
    localparam logic [THR_W-1:0] RST_IDLE_THR    = THR_W'(10 * MS_PER_MIN);
    localparam logic [THR_W-1:0] RST_GNSS_THR    = THR_W'(30 * MS_PER_MIN);
    localparam logic [THR_W-1:0] RST_SLEEP_THR   = THR_W'(120 * MS_PER_MIN);

    // Configuration, with minute settings held as millisecond thresholds.
    typedef struct packed {
        logic [15:0]      debounce_ms;
        logic [THR_W-1:0] idle_thr_ms;
        logic [THR_W-1:0] gnss_thr_ms;
        logic [THR_W-1:0] sleep_thr_ms;
        logic             charge_only_on_usb;
    } cfg_t;

    // Controller state carried from one item to the next.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] switch_off_anchor;
        logic        switch_off_armed;
        logic [31:0] idle_anchor;
        logic        idle_armed;
        logic [31:0] sleep_entered_at;
        logic        gnss_in_backup;
    } state_t;

    typedef struct packed {
        logic        boot;
        logic [31:0] now_ms;
        logic        switch_on;
        logic        usb_present;
        logic        battery_low_at_boot;
        logic        cutoff_requested;
        logic        link_connected;
        logic        motion_wake;
    } item_t;

    typedef struct packed {
        mode_t       mode;
        logic [4:0]  event_res;
        logic        gnss_escalate;
        logic        gnss_cold_start;
        logic        deep_sleep_request;
        logic        reset_request;
    } result_t;

    // Minutes to milliseconds.
    function automatic logic [THR_W-1:0] min_to_ms(input logic [MIN_W-1:0] minutes);
        logic [THR_W-1:0] prod;
        prod = THR_W'(minutes) * THR_W'(MS_PER_MIN);
        return prod;
    endfunction

endpackage

[hw/rtl/pmc_step.sv]
module pmc_step (
    input  pmc_pkg::item_t   item,
    input  pmc_pkg::state_t  state,
    input  pmc_pkg::cfg_t    cfg,
    output pmc_pkg::state_t  state_next,
    output pmc_pkg::result_t result
);
    import pmc_pkg::*;

    logic [31:0] sw_anchor_eff;
    logic [31:0] off_elapsed;
    logic        sw_held;
    logic [31:0] idle_anchor_eff;
    logic [31:0] idle_elapsed;
    logic [31:0] slept;
    logic [4:0]  ev;
    logic        esc;
    logic        cold;
    state_t      nxt;

    // Elapsed times, all modulo 2^32.
    assign sw_anchor_eff   = state.switch_off_armed ? state.switch_off_anchor : item.now_ms;
    assign off_elapsed     = item.now_ms - sw_anchor_eff;
    assign sw_held         = item.switch_on || (off_elapsed < {16'b0, cfg.debounce_ms});
    assign idle_anchor_eff = state.idle_armed ? state.idle_anchor : item.now_ms;
    assign idle_elapsed    = item.now_ms - idle_anchor_eff;
    assign slept           = item.now_ms - state.sleep_entered_at;

    // Mode transitions for one item.
    always_comb
    begin
        nxt  = state;
        ev   = EV_NONE;
        esc  = 1'b0;
        cold = 1'b0;
        if (item.boot)
        begin
            nxt = '0;
            if (!item.switch_on)
            begin
                nxt.mode = MODE_BWAIT;
                ev       = EV_BOOT_BWAIT;
            end
            else if (!item.usb_present && item.battery_low_at_boot)
            begin
                nxt.mode = MODE_DEEP;
                ev       = EV_BOOT_DEEP;
            end
            else if (cfg.charge_only_on_usb && item.usb_present)
            begin
                nxt.mode = MODE_CHG;
                ev       = EV_BOOT_CHG;
            end
            else
            begin
                nxt.mode = MODE_RUN;
                ev       = EV_BOOT_RUN;
            end
        end
        else
        begin
            case (state.mode)
                MODE_RUN:
                begin
                    if (item.cutoff_requested && !item.usb_present)
                    begin
                        nxt.mode = MODE_DEEP;
                        ev       = EV_RUN_CUTOFF;
                    end
                    else
                    begin
                        // The debounce check updates its anchor once it is evaluated.
                        nxt.switch_off_armed  = !item.switch_on;
                        nxt.switch_off_anchor = item.switch_on ? 32'd0 : sw_anchor_eff;
                        if (!sw_held)
                        begin
                            nxt.mode = MODE_BWAIT;
                            ev       = EV_RUN_SWITCH_OFF;
                        end
                        else if (cfg.charge_only_on_usb && item.usb_present)
                        begin
                            nxt.mode = MODE_CHG;
                            ev       = EV_RUN_USB;
                        end
                        else if (item.link_connected)
                        begin
                            nxt.idle_armed  = 1'b0;
                            nxt.idle_anchor = 32'd0;
                        end
                        else
                        begin
                            nxt.idle_armed  = 1'b1;
                            nxt.idle_anchor = idle_anchor_eff;
                            if (idle_elapsed >= {5'b0, cfg.idle_thr_ms})
                            begin
                                nxt.gnss_in_backup   = 1'b1;
                                nxt.sleep_entered_at = item.now_ms;
                                nxt.mode             = MODE_LIGHT;
                                ev                   = EV_RUN_IDLE;
                            end
                        end
                    end
                end
                MODE_CHG:
                begin
                    if (!item.usb_present)
                    begin
                        ev = EV_CHG_USB_GONE;
                    end
                    else
                    begin
                        nxt.switch_off_armed  = !item.switch_on;
                        nxt.switch_off_anchor = item.switch_on ? 32'd0 : sw_anchor_eff;
                        if (!sw_held)
                        begin
                            ev = EV_CHG_SWITCH_OFF;
                        end
                    end
                end
                MODE_BWAIT:
                begin
                    if (item.switch_on)
                    begin
                        ev = EV_BWAIT_SWITCH_ON;
                    end
                end
                MODE_LIGHT:
                begin
                    if (item.cutoff_requested && !item.usb_present)
                    begin
                        nxt.mode = MODE_DEEP;
                        ev       = EV_LIGHT_CUTOFF;
                    end
                    else
                    begin
                        nxt.switch_off_armed  = !item.switch_on;
                        nxt.switch_off_anchor = item.switch_on ? 32'd0 : sw_anchor_eff;
                        if (!sw_held)
                        begin
                            nxt.mode = MODE_BWAIT;
                            ev       = EV_LIGHT_SWITCH;
                        end
                        else if (item.link_connected || item.motion_wake)
                        begin
                            // Wake up: a cut GNSS needs a cold start.
                            cold            = !state.gnss_in_backup;
                            nxt.idle_armed  = 1'b0;
                            nxt.idle_anchor = 32'd0;
                            nxt.mode        = MODE_RUN;
                            ev = item.link_connected ? EV_LIGHT_LINK : EV_LIGHT_MOTION;
                        end
                        else
                        begin
                            if (state.gnss_in_backup && (slept >= {5'b0, cfg.gnss_thr_ms}))
                            begin
                                nxt.gnss_in_backup = 1'b0;
                                esc                = 1'b1;
                            end
                            if (slept >= {5'b0, cfg.sleep_thr_ms})
                            begin
                                nxt.mode = MODE_DEEP;
                                ev       = EV_LIGHT_TIMEOUT;
                            end
                        end
                    end
                end
                default:
                begin
                    nxt = state;
                end
            endcase
        end
    end

    // Result fields.
    always_comb
    begin
        state_next                = nxt;
        result.mode               = nxt.mode;
        result.event_res          = ev;
        result.gnss_escalate      = esc;
        result.gnss_cold_start    = cold;
        result.deep_sleep_request = ev inside {EV_BOOT_DEEP, EV_RUN_CUTOFF,
                                               EV_LIGHT_CUTOFF, EV_LIGHT_TIMEOUT};
        result.reset_request      = ev inside {EV_CHG_USB_GONE, EV_CHG_SWITCH_OFF,
                                               EV_BWAIT_SWITCH_ON};
    end

endmodule

[hw/rtl/power_mode_controller_core.sv]
// Power-mode controller.
// Input stream (s_axis_*): one transaction per item, either a boot
// classification (tuser = 1) or a periodic tick (tuser = 0), carrying a
// millisecond timestamp and the sampled switch, USB, battery, link and
// motion inputs. Output stream (m_axis_*): exactly one result transaction
// per input item, in order: the new mode, the transition code and the
// action requests.
// Configuration (cfg_*): five registers, which the user must write only
// while the block is idle; the block does not enforce this, and cfg_ready
// is always high. Minute settings are turned into millisecond thresholds
// by a multiplication when they are written. An item passes through an
// input register and a result register, with the step logic and the state
// update between them. Throughput is one item per cycle while the receiver
// does not stall. On a stall the result register holds, and the input
// register takes one more transaction only if it was empty.
// Reset clears the mode to running, all timers and the valid flags, and
// restores the configuration defaults.
module power_mode_controller_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input transaction: tdata = now_ms[31:0], switch_on, usb_present,
    // battery_low_at_boot, cutoff_requested, link_connected, motion_wake, pad.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata,
    // tuser = boot
    input  logic                           s_axis_tuser,
    // Result transaction: tdata = mode[2:0], event_res[4:0], gnss_escalate,
    // gnss_cold_start, deep_sleep_request, reset_request, pad.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pmc_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  state_reg;
    state_t  state_next;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    // Handshakes.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration register update.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:    cfg_next.debounce_ms        = cfg_data;
                CFG_IDLE_TMO:    cfg_next.idle_thr_ms        = min_to_ms(cfg_data[MIN_W-1:0]);
                CFG_GNSS_CUTOFF: cfg_next.gnss_thr_ms        = min_to_ms(cfg_data[MIN_W-1:0]);
                CFG_SLEEP_TMO:   cfg_next.sleep_thr_ms       = min_to_ms(cfg_data[MIN_W-1:0]);
                CFG_CHARGE_ONLY: cfg_next.charge_only_on_usb = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms        <= RST_DEBOUNCE_MS;
            cfg_reg.idle_thr_ms        <= RST_IDLE_THR;
            cfg_reg.gnss_thr_ms        <= RST_GNSS_THR;
            cfg_reg.sleep_thr_ms       <= RST_SLEEP_THR;
            cfg_reg.charge_only_on_usb <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.boot                <= s_axis_tuser;
            in_item_reg.now_ms              <= s_axis_tdata[31:0];
            in_item_reg.switch_on           <= s_axis_tdata[32];
            in_item_reg.usb_present         <= s_axis_tdata[33];
            in_item_reg.battery_low_at_boot <= s_axis_tdata[34];
            in_item_reg.cutoff_requested    <= s_axis_tdata[35];
            in_item_reg.link_connected      <= s_axis_tdata[36];
            in_item_reg.motion_wake         <= s_axis_tdata[37];
        end
    end

    // Step logic.
    pmc_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // Controller state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_res_reg.reset_request, out_res_reg.deep_sleep_request,
                            out_res_reg.gnss_cold_start, out_res_reg.gnss_escalate,
                            out_res_reg.event_res, out_res_reg.mode};

    // A deep-sleep request always leaves the controller in deep sleep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.deep_sleep_request) |-> (out_res_reg.mode == MODE_DEEP))
        else $error("deep-sleep request without deep-sleep mode");

    // A cold-start request only comes with a wake back into running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.gnss_cold_start) |->
        (out_res_reg.mode == MODE_RUN &&
         (out_res_reg.event_res == EV_LIGHT_LINK || out_res_reg.event_res == EV_LIGHT_MOTION)))
        else $error("GNSS cold start outside a wake transition");

    // The stored mode follows the last registered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg.mode == out_res_reg.mode))
        else $error("state mode differs from reported mode");

    // A held input item is not lost while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("pending input item dropped");

endmodule
